// File: hdl/yhgf_pkg.sv
//------------------------------------------------------------------------------
// Yaw heading glitch filter package
// Shared types and constants: commands, register indexes, counter slots,
// and the configuration, item, state and counter control records.
//------------------------------------------------------------------------------
`default_nettype none

package yhgf_pkg;

	typedef enum logic [1:0] {
		CMD_UPDATE  = 2'd0,
		CMD_SET_REF = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_MARGIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_PER_MS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REC_STEP_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REC_FRAMES     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ENC_TOLERANCE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_NEGATE     = 3'd7;

	localparam logic [1:0] EV_REJECT = 2'd0;
	localparam logic [1:0] EV_STALE  = 2'd1;
	localparam logic [1:0] EV_ACCEPT = 2'd2;
	localparam logic [1:0] EV_RESET  = 2'd3;
	localparam int unsigned EV_NUM   = 4;

	typedef struct packed {
		logic [15:0] step_margin;
		logic [15:0] stale_limit_ms;
		logic [15:0] rate_per_ms;
		logic [15:0] max_step;
		logic [15:0] recovery_step_limit;
		logic [7:0]  recovery_frames_needed;
		logic [15:0] encoder_tolerance;
		logic        yaw_negate;
	} cfg_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] yaw_raw;
		logic [31:0] frame_count;
		logic [31:0] sample_tick;
		logic [31:0] now_tick;
		logic [15:0] heading_in;
	} item_t;

	typedef struct packed {
		logic        valid_flag;
		logic [15:0] reference_yaw;
		logic [15:0] last_yaw;
		logic [15:0] recovery_last_yaw;
		logic [31:0] observed_frame;
		logic [31:0] last_accept_tick;
		logic        recovery_flag;
		logic [7:0]  recovery_count;
		logic [15:0] reference_heading;
		logic [15:0] current_heading;
	} state_t;

	typedef struct packed {
		logic clear_all;
		logic bump_reject;
		logic bump_stale;
		logic bump_accept;
		logic bump_reset;
	} ctr_ctl_t;

endpackage

`default_nettype wire

// File: hdl/yaw_heading_glitch_filter.sv
//------------------------------------------------------------------------------
// Yaw heading glitch filter
// Turns yaw samples into a heading, rejecting implausible yaw steps and
// recovering only after consistent frames that agree with the encoder.
//------------------------------------------------------------------------------
// The block takes one item per clock cycle while the result channel is not
// stalled. An accepted item is held in an input register; the step logic,
// whose longest path is the 16 by 16 bit product of elapsed time and
// rate_per_ms feeding the step limit compare, then updates the filter state
// and loads the result registers once the result channel is free. The status
// and counter outputs show the filter state after the item of the current
// result. Configuration writes are taken at any time and must only be issued
// while no item is in flight.
`default_nettype none

module yaw_heading_glitch_filter #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [yhgf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [yhgf_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    cmd,
	input  logic signed [15:0]            yaw_raw,
	input  logic [31:0]                   frame_count,
	input  logic [31:0]                   sample_tick,
	input  logic [31:0]                   now_tick,
	input  logic signed [15:0]            heading_in,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic signed [15:0]            heading,
	output logic                          nav_valid,
	output logic                          fresh,
	output logic                          in_recovery,
	output logic [COUNT_BITS-1:0]         rejected_total,
	output logic [COUNT_BITS-1:0]         stale_recovery_total,
	output logic [COUNT_BITS-1:0]         recovery_accept_total,
	output logic [COUNT_BITS-1:0]         recovery_reset_total
);
	import yhgf_pkg::*;

	cfg_t            cfg_q;
	item_t           item_s1;
	logic            valid_s1;
	state_t          st_q;
	state_t          st_nxt;
	ctr_ctl_t        ctr;
	logic            ok_nxt;
	logic            fresh_nxt;
	logic            ok_q;
	logic            fresh_q;
	logic            out_valid_q;
	logic            advance;
	logic [COUNT_BITS-1:0] ctr_q [EV_NUM];

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_margin <= 16'd182;
			cfg_q.stale_limit_ms <= 16'd100;
			cfg_q.rate_per_ms <= 16'd10;
			cfg_q.max_step <= 16'd5461;
			cfg_q.recovery_step_limit <= 16'd364;
			cfg_q.recovery_frames_needed <= 8'd5;
			cfg_q.encoder_tolerance <= 16'd2731;
			cfg_q.yaw_negate <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_STEP_MARGIN:    cfg_q.step_margin <= cfg_data;
				CFG_STALE_LIMIT:    cfg_q.stale_limit_ms <= cfg_data;
				CFG_RATE_PER_MS:    cfg_q.rate_per_ms <= cfg_data;
				CFG_MAX_STEP:       cfg_q.max_step <= cfg_data;
				CFG_REC_STEP_LIMIT: cfg_q.recovery_step_limit <= cfg_data;
				CFG_REC_FRAMES:     cfg_q.recovery_frames_needed <= cfg_data[7:0];
				CFG_ENC_TOLERANCE:  cfg_q.encoder_tolerance <= cfg_data;
				CFG_YAW_NEGATE:     cfg_q.yaw_negate <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd <= cmd_t'(cmd);
			item_s1.yaw_raw <= yaw_raw;
			item_s1.frame_count <= frame_count;
			item_s1.sample_tick <= sample_tick;
			item_s1.now_tick <= now_tick;
			item_s1.heading_in <= heading_in;
		end
	end

	yhgf_step u_step (
		.cfg    (cfg_q),
		.st     (st_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.ctr    (ctr),
		.ok     (ok_nxt),
		.fresh  (fresh_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			for (int i = 0; i < EV_NUM; i++) begin
				ctr_q[i] <= '0;
			end
		end else if (advance) begin
			st_q <= st_nxt;
			if (ctr.clear_all) begin
				for (int i = 0; i < EV_NUM; i++) begin
					ctr_q[i] <= '0;
				end
			end else begin
				if (ctr.bump_reject) begin
					ctr_q[EV_REJECT] <= ctr_q[EV_REJECT] + COUNT_BITS'(1);
				end
				if (ctr.bump_stale) begin
					ctr_q[EV_STALE] <= ctr_q[EV_STALE] + COUNT_BITS'(1);
				end
				if (ctr.bump_accept) begin
					ctr_q[EV_ACCEPT] <= ctr_q[EV_ACCEPT] + COUNT_BITS'(1);
				end
				if (ctr.bump_reset) begin
					ctr_q[EV_RESET] <= ctr_q[EV_RESET] + COUNT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ok_q <= ok_nxt;
			fresh_q <= fresh_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign ok = ok_q;
	assign fresh = fresh_q;
	assign heading = st_q.current_heading;
	assign nav_valid = st_q.valid_flag;
	assign in_recovery = st_q.recovery_flag;
	assign rejected_total = ctr_q[EV_REJECT];
	assign stale_recovery_total = ctr_q[EV_STALE];
	assign recovery_accept_total = ctr_q[EV_ACCEPT];
	assign recovery_reset_total = ctr_q[EV_RESET];

endmodule

`default_nettype wire

// File: hdl/yhgf_step.sv
//------------------------------------------------------------------------------
// Yaw heading glitch filter step logic
// Computes the next filter state, counter events, ok and fresh for one item.
//------------------------------------------------------------------------------
`default_nettype none

module yhgf_step (
	input  yhgf_pkg::cfg_t     cfg,
	input  yhgf_pkg::state_t   st,
	input  yhgf_pkg::item_t    item,
	output yhgf_pkg::state_t   st_nxt,
	output yhgf_pkg::ctr_ctl_t ctr,
	output logic               ok,
	output logic               fresh
);
	import yhgf_pkg::*;

	// Magnitude of a wrapped 16-bit angle difference; the most negative
	// angle maps to half a turn.
	function automatic logic [16:0] ang_mag(input logic [15:0] d);
		logic [16:0] m;
		if (d[15]) begin
			m = {1'b0, ~d} + 17'd1;
		end else begin
			m = {1'b0, d};
		end
		return m;
	endfunction

	logic        usable;
	logic [31:0] elapsed;
	logic        late_gap;
	logic [15:0] el_clamp;
	logic [31:0] prod;
	logic [32:0] lim;
	logic [15:0] allowed;
	logic [15:0] rel;
	logic [15:0] cand;
	logic [16:0] step_mag;
	logic [16:0] enc_mag;
	logic [16:0] rec_mag;
	logic [7:0]  cnt_inc;
	state_t      latch_st;
	state_t      acc_st;

	always_comb begin
		usable = (item.frame_count != 32'd0) &&
			((item.now_tick - item.sample_tick) <= {16'd0, cfg.stale_limit_ms});
		elapsed = item.sample_tick - st.last_accept_tick;
		late_gap = elapsed > {16'd0, cfg.stale_limit_ms};
		el_clamp = late_gap ? cfg.stale_limit_ms : elapsed[15:0];
		prod = {16'd0, el_clamp} * {16'd0, cfg.rate_per_ms};
		lim = {1'b0, prod} + {17'd0, cfg.step_margin};
		allowed = (lim > {17'd0, cfg.max_step}) ? cfg.max_step : lim[15:0];

		rel = item.yaw_raw - st.reference_yaw;
		if (cfg.yaw_negate) begin
			rel = 16'd0 - rel;
		end
		cand = st.reference_heading + rel;

		step_mag = ang_mag(item.yaw_raw - st.last_yaw);
		enc_mag = ang_mag(cand - item.heading_in);
		rec_mag = ang_mag(item.yaw_raw - st.recovery_last_yaw);
		cnt_inc = (st.recovery_count < cfg.recovery_frames_needed) ?
			st.recovery_count + 8'd1 : st.recovery_count;

		latch_st = '0;
		latch_st.valid_flag = 1'b1;
		latch_st.reference_yaw = item.yaw_raw;
		latch_st.last_yaw = item.yaw_raw;
		latch_st.recovery_last_yaw = item.yaw_raw;
		latch_st.observed_frame = item.frame_count;
		latch_st.last_accept_tick = item.sample_tick;
		latch_st.reference_heading = item.heading_in;
		latch_st.current_heading = item.heading_in;

		acc_st = st;
		acc_st.observed_frame = item.frame_count;
		acc_st.last_yaw = item.yaw_raw;
		acc_st.last_accept_tick = item.sample_tick;
		acc_st.current_heading = cand;
		acc_st.recovery_flag = 1'b0;
		acc_st.recovery_count = 8'd0;

		st_nxt = st;
		ctr = '0;
		ok = 1'b0;

		unique case (item.cmd)
			CMD_UPDATE: begin
				if (usable && (item.frame_count != st.observed_frame)) begin
					ok = 1'b1;
					if (!st.valid_flag) begin
						st_nxt = latch_st;
						ctr.clear_all = 1'b1;
					end else if (!late_gap && (step_mag <= {1'b0, allowed})) begin
						st_nxt = acc_st;
					end else begin
						ctr.bump_reject = 1'b1;
						st_nxt.observed_frame = item.frame_count;
						st_nxt.recovery_last_yaw = item.yaw_raw;
						if (!st.recovery_flag) begin
							st_nxt.recovery_flag = 1'b1;
							st_nxt.recovery_count = 8'd1;
							ctr.bump_stale = late_gap;
						end else if ((rec_mag > {1'b0, cfg.recovery_step_limit}) ||
							(enc_mag > {1'b0, cfg.encoder_tolerance})) begin
							st_nxt.recovery_count = 8'd1;
							ctr.bump_reset = 1'b1;
						end else if (cnt_inc < cfg.recovery_frames_needed) begin
							st_nxt.recovery_count = cnt_inc;
						end else begin
							ctr.bump_accept = 1'b1;
							st_nxt = acc_st;
							st_nxt.recovery_last_yaw = item.yaw_raw;
						end
					end
				end
			end
			CMD_SET_REF: begin
				if (usable) begin
					ok = 1'b1;
					st_nxt = latch_st;
					ctr.clear_all = 1'b1;
				end
			end
			CMD_CLEAR: begin
				st_nxt = '0;
				ctr.clear_all = 1'b1;
			end
			CMD_NOP: begin
				st_nxt = st;
			end
			default: begin
				st_nxt = st;
			end
		endcase

		fresh = st_nxt.valid_flag && !st_nxt.recovery_flag &&
			((item.now_tick - st_nxt.last_accept_tick) <= {16'd0, cfg.stale_limit_ms});
	end

endmodule

`default_nettype wire

// File: hdl/yhgf_checker.sv
//------------------------------------------------------------------------------
// Yaw heading glitch filter checker
// Port-level assertions on the result channel, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module yhgf_checker #(
	parameter int unsigned COUNT_BITS = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  ok,
	input logic signed [15:0]    heading,
	input logic                  nav_valid,
	input logic                  fresh,
	input logic                  in_recovery,
	input logic [COUNT_BITS-1:0] rejected_total,
	input logic [COUNT_BITS-1:0] stale_recovery_total,
	input logic [COUNT_BITS-1:0] recovery_accept_total,
	input logic [COUNT_BITS-1:0] recovery_reset_total
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(heading) &&
			$stable(fresh) && $stable(rejected_total))
		else $error("result changed while stalled");

	// Without a reference the filter is fully cleared.
	a_no_ref_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !nav_valid |-> heading == 16'sd0 && !in_recovery &&
			rejected_total == '0 && stale_recovery_total == '0 &&
			recovery_accept_total == '0 && recovery_reset_total == '0)
		else $error("state present without a reference");

	// A recovering filter never reports a fresh heading.
	a_recovery_not_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_recovery |-> !fresh)
		else $error("fresh while in recovery");

	// Fresh requires a latched reference.
	a_fresh_needs_ref: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fresh |-> nav_valid)
		else $error("fresh without a reference");

endmodule

bind yaw_heading_glitch_filter yhgf_checker #(.COUNT_BITS(COUNT_BITS)) u_yhgf_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.out_valid             (out_valid),
	.out_ready             (out_ready),
	.ok                    (ok),
	.heading               (heading),
	.nav_valid             (nav_valid),
	.fresh                 (fresh),
	.in_recovery           (in_recovery),
	.rejected_total        (rejected_total),
	.stale_recovery_total  (stale_recovery_total),
	.recovery_accept_total (recovery_accept_total),
	.recovery_reset_total  (recovery_reset_total)
);

`default_nettype wire
